>>> rtl/pwbd_pkg.sv
// Shared types and constants of the pulse width bit decoder.
package pwbd_pkg;

   localparam int CFG_W    = 10;
   localparam int RUN_W    = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [RUN_W-1:0] RUN_SAT = 11'd2047;

   localparam logic [CFG_W-1:0] PREAMBLE_MIN_RESET   = 10'd20;
   localparam logic [CFG_W-1:0] LONG_GAP_MIN_RESET   = 10'd11;
   localparam logic [CFG_W-1:0] LONG_PULSE_MIN_RESET = 10'd13;

   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_MIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GAP_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PULSE_MIN = 2'd2;

   typedef enum logic [2:0] {
      PH_SEARCH  = 3'b001,
      PH_COLLECT = 3'b010,
      PH_DONE    = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'b01,
      ST_DRAIN  = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic pixel_on;
      logic end_of_column;
   } req_type;

   typedef struct packed {
      logic bit_value;
      logic last_bit;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      logic take_pixel;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit_start;
      logic emit_last;
      logic emit_pending;
   } status_type;

endpackage

>>> rtl/pwbd_datapath.sv
// Datapath: run measurement, bit decoding, bit buffer and output register.
module pwbd_datapath #(
   parameter int BUFFER_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [pwbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwbd_pkg::CFG_W-1:0]        csr_wdata,
   input  pwbd_pkg::req_type                 req_data,
   input  pwbd_pkg::cmd_type                 cmd,
   output pwbd_pkg::status_type              status,
   output pwbd_pkg::rsp_type                 rsp_data
);

   localparam int CNT_W = $clog2(BUFFER_BITS + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int RUN_W = pwbd_pkg::RUN_W;
   localparam int CFG_W = pwbd_pkg::CFG_W;

   logic [CFG_W-1:0]       cfg_pre_ff, cfg_pre_in;
   logic [CFG_W-1:0]       cfg_gap_ff, cfg_gap_in;
   logic [CFG_W-1:0]       cfg_pulse_ff, cfg_pulse_in;
   pwbd_pkg::phase_type    phase_ff, phase_in;
   logic                   prev_ff, prev_in;
   logic                   seen_rise_ff, seen_rise_in;
   logic                   pulse_seen_ff, pulse_seen_in;
   logic [RUN_W-1:0]       run_ff, run_in;
   logic [RUN_W-1:0]       gap_ff, gap_in;
   logic                   first_gap_ff, first_gap_in;
   logic                   prior_long_ff, prior_long_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   dropped_ff, dropped_in;
   logic [BUFFER_BITS-1:0] store_ff, store_in;
   logic [CNT_W-1:0]       emit_left_ff, emit_left_in;
   logic                   emit_drop_ff, emit_drop_in;
   pwbd_pkg::rsp_type      rsp_ff, rsp_in;

   logic             pix, eoc, same, rise, fall, pulse_end;
   logic             is_pre, gap_long, pulse_long;
   logic             start_collect, do_collect, emit;
   logic [1:0]       zeros, push_z, push_o;
   logic [SUM_W-1:0] sum;
   logic             over;
   logic [CNT_W-1:0] new_count;
   logic             new_dropped;

   // Run classification and bit counts for a pulse that ends now
   always_comb begin
      pix        = req_data.pixel_on;
      eoc        = req_data.end_of_column;
      same       = (pix == prev_ff);
      rise       = pix && !prev_ff;
      fall       = !pix && prev_ff;
      pulse_end  = fall && seen_rise_ff;
      is_pre     = run_ff >= RUN_W'(cfg_pre_ff);
      gap_long   = gap_ff >= RUN_W'(cfg_gap_ff);
      pulse_long = run_ff >= RUN_W'(cfg_pulse_ff);

      start_collect = pulse_end && (phase_ff == pwbd_pkg::PH_SEARCH) && is_pre && pulse_seen_ff;
      do_collect    = pulse_end && (phase_ff == pwbd_pkg::PH_COLLECT);
      emit          = do_collect && is_pre;

      if (gap_long) begin
         zeros = (first_gap_ff || is_pre) ? 2'd1 : 2'd2;
      end else if ((!first_gap_ff && !is_pre) || (is_pre && !first_gap_ff && prior_long_ff)) begin
         zeros = 2'd1;
      end else begin
         zeros = 2'd0;
      end

      push_z = do_collect ? zeros : 2'd0;
      if (do_collect && !is_pre) begin
         push_o = pulse_long ? 2'd2 : 2'd1;
      end else begin
         push_o = 2'd0;
      end

      sum         = SUM_W'(count_ff) + SUM_W'(push_z) + SUM_W'(push_o);
      over        = sum > SUM_W'(BUFFER_BITS);
      new_count   = over ? CNT_W'(BUFFER_BITS) : sum[CNT_W-1:0];
      new_dropped = dropped_ff || over;
   end

   // Next state
   always_comb begin
      cfg_pre_in    = cfg_pre_ff;
      cfg_gap_in    = cfg_gap_ff;
      cfg_pulse_in  = cfg_pulse_ff;
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      seen_rise_in  = seen_rise_ff;
      pulse_seen_in = pulse_seen_ff;
      run_in        = run_ff;
      gap_in        = gap_ff;
      first_gap_in  = first_gap_ff;
      prior_long_in = prior_long_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      store_in      = store_ff;
      emit_left_in  = emit_left_ff;
      emit_drop_in  = emit_drop_ff;
      rsp_in        = rsp_ff;

      if (csr_write) begin
         case (csr_index)
            pwbd_pkg::CSR_PREAMBLE_MIN:   cfg_pre_in   = csr_wdata;
            pwbd_pkg::CSR_LONG_GAP_MIN:   cfg_gap_in   = csr_wdata;
            pwbd_pkg::CSR_LONG_PULSE_MIN: cfg_pulse_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.take_pixel) begin
         // Run lengths
         if (same) begin
            run_in = (run_ff == pwbd_pkg::RUN_SAT) ? run_ff : run_ff + RUN_W'(1);
         end else begin
            run_in = RUN_W'(1);
         end
         if (rise) begin
            seen_rise_in = 1'b1;
            gap_in       = run_ff;
         end
         prev_in = pix;

         if (pulse_end && (phase_ff == pwbd_pkg::PH_SEARCH)) begin
            pulse_seen_in = 1'b1;
         end
         if (start_collect) begin
            phase_in      = pwbd_pkg::PH_COLLECT;
            first_gap_in  = 1'b1;
            prior_long_in = 1'b0;
            count_in      = '0;
            dropped_in    = 1'b0;
         end
         if (do_collect) begin
            dropped_in = new_dropped;
            // Write the pushed bits: gap zeros first, then pulse ones
            for (int p = 0; p < BUFFER_BITS; p++) begin
               if (SUM_W'(p) >= SUM_W'(count_ff) && SUM_W'(p) < sum) begin
                  store_in[p] = (SUM_W'(p) - SUM_W'(count_ff)) >= SUM_W'(push_z);
               end
            end
            if (is_pre) begin
               phase_in     = pwbd_pkg::PH_DONE;
               count_in     = '0;
               emit_left_in = new_count;
               emit_drop_in = new_dropped;
            end else begin
               count_in      = new_count;
               prior_long_in = pulse_long;
               first_gap_in  = 1'b0;
            end
         end

         // End of column: drop all column state
         if (eoc) begin
            phase_in      = pwbd_pkg::PH_SEARCH;
            prev_in       = 1'b1;
            seen_rise_in  = 1'b0;
            pulse_seen_in = 1'b0;
            run_in        = '0;
            gap_in        = '0;
            first_gap_in  = 1'b1;
            prior_long_in = 1'b0;
            count_in      = '0;
            dropped_in    = 1'b0;
         end
      end

      // Drain: oldest bit sits at the bottom of the buffer
      if (cmd.load_out) begin
         rsp_in.bit_value = store_ff[0];
         rsp_in.last_bit  = (emit_left_ff == CNT_W'(1));
         rsp_in.overflow  = emit_drop_ff;
         store_in         = store_ff >> 1;
         emit_left_in     = emit_left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pre_ff    <= pwbd_pkg::PREAMBLE_MIN_RESET;
         cfg_gap_ff    <= pwbd_pkg::LONG_GAP_MIN_RESET;
         cfg_pulse_ff  <= pwbd_pkg::LONG_PULSE_MIN_RESET;
         phase_ff      <= pwbd_pkg::PH_SEARCH;
         prev_ff       <= 1'b1;
         seen_rise_ff  <= 1'b0;
         pulse_seen_ff <= 1'b0;
         run_ff        <= '0;
         gap_ff        <= '0;
         first_gap_ff  <= 1'b1;
         prior_long_ff <= 1'b0;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         emit_left_ff  <= '0;
         emit_drop_ff  <= 1'b0;
      end else begin
         cfg_pre_ff    <= cfg_pre_in;
         cfg_gap_ff    <= cfg_gap_in;
         cfg_pulse_ff  <= cfg_pulse_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         seen_rise_ff  <= seen_rise_in;
         pulse_seen_ff <= pulse_seen_in;
         run_ff        <= run_in;
         gap_ff        <= gap_in;
         first_gap_ff  <= first_gap_in;
         prior_long_ff <= prior_long_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         emit_left_ff  <= emit_left_in;
         emit_drop_ff  <= emit_drop_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      status.emit_start   = cmd.take_pixel && emit && (new_count != '0);
      status.emit_last    = (emit_left_ff == CNT_W'(1));
      status.emit_pending = (emit_left_ff != '0);
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/pwbd_controller.sv
// Controller: takes pixels, drains a run one bit per cycle unless stalled.
module pwbd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pwbd_pkg::status_type status,
   output pwbd_pkg::cmd_type    cmd
);

   pwbd_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   always_comb begin
      state_in       = state_ff;
      out_free       = !rsp_valid_ff || !rsp_stall;
      cmd.take_pixel = 1'b0;
      cmd.load_out   = 1'b0;
      req_stall      = 1'b1;

      case (state_ff)
         pwbd_pkg::ST_ACCEPT: begin
            req_stall      = 1'b0;
            cmd.take_pixel = req_valid;
            if (req_valid && status.emit_start) begin
               state_in = pwbd_pkg::ST_DRAIN;
            end
         end
         pwbd_pkg::ST_DRAIN: begin
            cmd.load_out = out_free && status.emit_pending;
            // leave once the final bit moves to the output register
            if (cmd.load_out && status.emit_last) begin
               state_in = pwbd_pkg::ST_ACCEPT;
            end
         end
         default: begin
            state_in = pwbd_pkg::ST_ACCEPT;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwbd_pkg::ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pwbd_pkg::ST_DRAIN))
      else $error("result appeared outside a drain");

   a_drain_has_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwbd_pkg::ST_DRAIN) |-> status.emit_pending)
      else $error("drain state with an empty bit run");

   a_no_take_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwbd_pkg::ST_DRAIN) |-> !cmd.take_pixel)
      else $error("pixel taken while draining");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.load_out)
      else $error("output register overwritten while stalled");
`endif

endmodule

>>> rtl/pulse_width_bit_decoder.sv
// Top level of the pulse width bit decoder.
// Takes one binarized pixel of a camera column per request, with an end-of-column
// mark, and measures on and off run lengths. The first wide preamble pulse that is
// not the first pulse of the column opens a packet; each following gap gives zero,
// one or two 0 bits and each data pulse one or two 1 bits, by the long-gap and
// long-pulse thresholds. When the second preamble pulse ends, the buffered bits
// come out as a run of results, the last one marked by last_bit, each carrying
// overflow if bits were dropped because the buffer of BUFFER_BITS entries filled.
// A column without a second preamble gives no results; the rest of a column after
// a packet is ignored. Rate: one pixel per cycle while decoding. The pixel that
// ends a packet of N buffered bits is followed by a drain of the bit buffer, with
// req_stall high, through the single output register, one bit a cycle unless
// rsp_stall holds results back. Configuration registers (0: preamble_min_width,
// 1: long_gap_min, 2: long_pulse_min, 10 bits each) are always ready. The user
// must write them only while the block is idle; the block does not enforce this.
module pulse_width_bit_decoder #(
   parameter int BUFFER_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pwbd_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pwbd_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pwbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwbd_pkg::CFG_W-1:0]     csr_wdata
);

   pwbd_pkg::cmd_type    cmd;
   pwbd_pkg::status_type status;

   // Register writes never wait
   assign csr_ready = 1'b1;

   pwbd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pwbd_datapath #(
      .BUFFER_BITS (BUFFER_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
